>>> sv/afib1_pkg.sv
`timescale 1ns / 1ps
package afib1_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_IDX_REP_RATIO    = 2'd0;
  localparam logic [1:0] CFG_IDX_NOMINAL_FLIP = 2'd1;

  localparam logic [12:0] REP_RATIO_RST    = 13'd1280;
  localparam logic [11:0] NOMINAL_FLIP_RST = 12'd880;

  // Fixed-point constants: one in Q16, and 90 and 180 degrees in Q16.
  localparam logic [16:0] Q16_ONE   = 17'd65536;
  localparam logic [23:0] DEG90_Q16 = 24'd5898240;
  localparam logic [23:0] DEG180_Q16 = 24'd11796480;
  localparam logic [23:0] RATIO_MAX = 24'hFF_FFFF;

  // atan(2^-i) in degrees, Q16, rounded.
  localparam logic [21:0] ATAN_TAB [32] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
    22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833, 22'd917,
    22'd458, 22'd229, 22'd115, 22'd57, 22'd29, 22'd14, 22'd7, 22'd4, 22'd2,
    22'd1, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0
  };

  // Sideband carried alongside each pipelined unit.
  typedef struct packed {
    logic zero;
    logic sat;
  } rdiv_pay_t;

  typedef struct packed {
    logic        zero;
    logic        byp;
    logic        neg_fix;
    logic        sgn;
    logic [16:0] cfix;
  } cdiv_pay_t;

  typedef struct packed {
    logic        zero;
    logic        neg;
    logic [16:0] cmag;
  } sq_pay_t;

  typedef struct packed {
    logic zero;
    logic neg;
  } cor_pay_t;

  typedef struct packed {
    logic        zero;
    logic        sat;
    logic [13:0] fa;
  } bdiv_pay_t;

endpackage

>>> sv/afib1_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage. The caller
// guarantees that the starting remainder is below the divisor.
module afib1_div
  #(
    parameter int BW = 16,
    parameter int QW = 24,
    parameter int PW = 2
  )
  (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          ce,
    input  logic          in_valid,
    input  logic [BW-1:0] in_rem,
    input  logic [QW-1:0] in_low,
    input  logic [BW-1:0] in_div,
    input  logic [PW-1:0] in_pay,
    output logic          out_valid,
    output logic [QW-1:0] out_quo,
    output logic [PW-1:0] out_pay
  );

  logic          vld_r [QW];
  logic [BW-1:0] rem_r [QW];
  logic [QW-1:0] low_r [QW];
  logic [BW-1:0] div_r [QW];
  logic [QW-1:0] quo_r [QW];
  logic [PW-1:0] pay_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic          vld_i;
    logic [BW-1:0] rem_i;
    logic [QW-1:0] low_i;
    logic [BW-1:0] div_i;
    logic [QW-1:0] quo_i;
    logic [PW-1:0] pay_i;
    logic [BW:0]   trial;
    logic [BW:0]   diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign vld_i = in_valid;
      assign rem_i = in_rem;
      assign low_i = in_low;
      assign div_i = in_div;
      assign quo_i = '0;
      assign pay_i = in_pay;
    end else begin : g_next
      assign vld_i = vld_r[k-1];
      assign rem_i = rem_r[k-1];
      assign low_i = low_r[k-1];
      assign div_i = div_r[k-1];
      assign quo_i = quo_r[k-1];
      assign pay_i = pay_r[k-1];
    end

    assign trial = {rem_i, low_i[QW-1]};
    assign diff  = trial - {1'b0, div_i};
    assign ge    = (trial >= {1'b0, div_i});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (ce) begin
        vld_r[k] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        rem_r[k] <= ge ? diff[BW-1:0] : trial[BW-1:0];
        low_r[k] <= low_i << 1;
        div_r[k] <= div_i;
        quo_r[k] <= {quo_i[QW-2:0], ge};
        pay_r[k] <= pay_i;
      end
    end
  end

  assign out_valid = vld_r[QW-1];
  assign out_quo   = quo_r[QW-1];
  assign out_pay   = pay_r[QW-1];

endmodule

>>> sv/afib1_sqrt.sv
`timescale 1ns / 1ps
// Pipelined integer square root, one root bit per stage.
module afib1_sqrt
  #(
    parameter int K  = 31,
    parameter int PW = 19
  )
  (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            ce,
    input  logic            in_valid,
    input  logic [2*K-1:0]  in_val,
    input  logic [PW-1:0]   in_pay,
    output logic            out_valid,
    output logic [K-1:0]    out_root,
    output logic [PW-1:0]   out_pay
  );

  logic           vld_r  [K];
  logic [K+1:0]   rem_r  [K];
  logic [K-1:0]   root_r [K];
  logic [2*K-1:0] val_r  [K];
  logic [PW-1:0]  pay_r  [K];

  for (genvar k = 0; k < K; k++) begin : g_stage
    logic           vld_i;
    logic [K+1:0]   rem_i;
    logic [K-1:0]   root_i;
    logic [2*K-1:0] val_i;
    logic [PW-1:0]  pay_i;
    logic [K+1:0]   rem_sh;
    logic [K+1:0]   trial;
    logic           ge;

    if (k == 0) begin : g_first
      assign vld_i  = in_valid;
      assign rem_i  = '0;
      assign root_i = '0;
      assign val_i  = in_val;
      assign pay_i  = in_pay;
    end else begin : g_next
      assign vld_i  = vld_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign root_i = root_r[k-1];
      assign val_i  = val_r[k-1];
      assign pay_i  = pay_r[k-1];
    end

    assign rem_sh = {rem_i[K-1:0], val_i[2*K-1:2*K-2]};
    assign trial  = {root_i, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (ce) begin
        vld_r[k] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        rem_r[k]  <= ge ? (rem_sh - trial) : rem_sh;
        root_r[k] <= {root_i[K-2:0], ge};
        val_r[k]  <= val_i << 2;
        pay_r[k]  <= pay_i;
      end
    end
  end

  assign out_valid = vld_r[K-1];
  assign out_root  = root_r[K-1];
  assign out_pay   = pay_r[K-1];

endmodule

>>> sv/afib1_cordic.sv
`timescale 1ns / 1ps
// Pipelined CORDIC in vectoring mode. Each stage rotates toward y = 0 and
// accumulates the matching arctangent in degrees, Q16.
module afib1_cordic
  import afib1_pkg::*;
  #(
    parameter int STEPS = 16,
    parameter int PW    = 2
  )
  (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               ce,
    input  logic               in_valid,
    input  logic [30:0]        in_x,
    input  logic [30:0]        in_y,
    input  logic [PW-1:0]      in_pay,
    output logic               out_valid,
    output logic signed [24:0] out_z,
    output logic [PW-1:0]      out_pay
  );

  logic               vld_r [STEPS];
  logic signed [33:0] x_r   [STEPS];
  logic signed [33:0] y_r   [STEPS];
  logic signed [24:0] z_r   [STEPS];
  logic [PW-1:0]      pay_r [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_stage
    logic               vld_i;
    logic signed [33:0] x_i;
    logic signed [33:0] y_i;
    logic signed [24:0] z_i;
    logic [PW-1:0]      pay_i;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [24:0] at;

    if (k == 0) begin : g_first
      assign vld_i = in_valid;
      assign x_i   = signed'({3'b0, in_x});
      assign y_i   = signed'({3'b0, in_y});
      assign z_i   = '0;
      assign pay_i = in_pay;
    end else begin : g_next
      assign vld_i = vld_r[k-1];
      assign x_i   = x_r[k-1];
      assign y_i   = y_r[k-1];
      assign z_i   = z_r[k-1];
      assign pay_i = pay_r[k-1];
    end

    assign dx = y_i >>> k;
    assign dy = x_i >>> k;
    assign at = signed'({3'b0, ATAN_TAB[k]});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (ce) begin
        vld_r[k] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        if (y_i > 0) begin
          x_r[k] <= x_i + dx;
          y_r[k] <= y_i - dy;
          z_r[k] <= z_i + at;
        end else begin
          x_r[k] <= x_i - dx;
          y_r[k] <= y_i + dy;
          z_r[k] <= z_i - at;
        end
        pay_r[k] <= pay_i;
      end
    end
  end

  assign out_valid = vld_r[STEPS-1];
  assign out_z     = z_r[STEPS-1];
  assign out_pay   = pay_r[STEPS-1];

endmodule

>>> sv/afi_flip_angle_b1_map_top.sv
`timescale 1ns / 1ps
// Actual-flip-angle B1 mapping, one voxel per beat. Each input beat carries
// the two dual-repetition magnitudes of one voxel; each output beat carries
// the flip angle in 1/64 degree, B1 as angle over nominal flip in unsigned
// Q4.12 (saturated), and a flag that is set when the first magnitude is zero,
// in which case both numbers are zero. The path is a deep pipeline: a
// bit-per-stage divider forms the signal ratio, a multiply and a second
// divider form the cosine estimate, a bit-per-stage square root and an
// ACOS_STEPS-stage CORDIC form the arccosine, and a third divider forms B1.
// A voxel is accepted every cycle while the output side keeps up. The
// output register is backed by a one-beat skid buffer; when that buffer
// fills the whole pipeline holds and in_tready drops, so nothing is lost or
// repeated. The two registers are written through the cfg port, which is
// always ready, and should be written only while no voxel is in flight.
module afi_flip_angle_b1_map_top
  import afib1_pkg::*;
  #(
    parameter int SIGNAL_BITS = 16,
    parameter int ACOS_STEPS  = 16
  )
  (
    input  logic        clk,
    input  logic        rst_n,
    // Input voxel: [15:0] signal1, [31:16] signal2.
    input  logic        in_tvalid,
    output logic        in_tready,
    input  logic [31:0] in_tdata,
    // Result: [13:0] flip_angle, [29:14] b1_ratio, [31:30] zero padding.
    output logic        out_tvalid,
    input  logic        out_tready,
    output logic [31:0] out_tdata,
    // Result flag: [0] zero_signal.
    output logic        out_tuser,
    // Register write: index 0 rep_ratio, index 1 nominal_flip.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data
  );

  localparam logic [15:0] SIG_MASK = (SIGNAL_BITS >= 16) ? 16'hFFFF :
                                     16'((17'd1 << SIGNAL_BITS) - 17'd1);

  // Configuration registers.
  logic [12:0] rep_ratio_r;
  logic [11:0] nominal_flip_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rep_ratio_r    <= REP_RATIO_RST;
      nominal_flip_r <= NOMINAL_FLIP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IDX_REP_RATIO:    rep_ratio_r    <= cfg_data;
        CFG_IDX_NOMINAL_FLIP: nominal_flip_r <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // The pipeline advances whenever the skid buffer is empty.
  logic ce;
  logic skid_valid_r;
  assign ce        = !skid_valid_r;
  assign in_tready = ce;

  // Input stage.
  logic        v0_r;
  logic [15:0] s1_r;
  logic [15:0] s2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (ce) begin
      v0_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s1_r <= in_tdata[15:0] & SIG_MASK;
      s2_r <= in_tdata[31:16] & SIG_MASK;
    end
  end

  // Ratio signal2 / signal1 in Q8.16. It saturates when signal2 reaches
  // 256 times signal1; otherwise the quotient fits in 24 bits.
  rdiv_pay_t   rdp_in;
  rdiv_pay_t   rdp_out;
  logic        rdv_out;
  logic [23:0] rq_out;

  assign rdp_in.zero = (s1_r == 16'd0);
  assign rdp_in.sat  = ({8'd0, s2_r} >= {s1_r, 8'd0});

  afib1_div #(.BW(16), .QW(24), .PW($bits(rdiv_pay_t))) u_ratio_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .in_valid  (v0_r),
    .in_rem    ({8'd0, s2_r[15:8]}),
    .in_low    ({s2_r[7:0], 16'd0}),
    .in_div    (s1_r),
    .in_pay    (rdp_in),
    .out_valid (rdv_out),
    .out_quo   (rq_out),
    .out_pay   (rdp_out)
  );

  // Stage A: saturated ratio.
  logic        va_r;
  logic        za_r;
  logic [23:0] ratio_r;
  // Stage B: ratio times TR ratio, and the denominator.
  logic        vb_r;
  logic        zb_r;
  logic [36:0] prod_r;
  logic signed [25:0] den_r;
  // Stage C: numerator.
  logic        vc_r;
  logic        zc_r;
  logic signed [30:0] num_r;
  logic signed [25:0] denc_r;
  // Stage D: magnitudes and signs.
  logic        vd_r;
  logic        zd_r;
  logic [29:0] an_r;
  logic [24:0] ad_r;
  logic        sgn_r;
  logic        denz_r;
  logic        numnz_r;
  logic        numneg_r;
  // Stage E: clamp decision ahead of the cosine divider.
  logic        ve_r;
  cdiv_pay_t   cdp_r;
  logic [23:0] an24_r;
  logic [23:0] ad24_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      ve_r <= 1'b0;
    end else if (ce) begin
      va_r <= rdv_out;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
      ve_r <= vd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      za_r    <= rdp_out.zero;
      ratio_r <= rdp_out.sat ? RATIO_MAX : rq_out;

      zb_r   <= za_r;
      prod_r <= 37'(ratio_r * rep_ratio_r);
      den_r  <= signed'({5'd0, rep_ratio_r, 8'd0}) - signed'({2'd0, ratio_r});

      zc_r   <= zb_r;
      num_r  <= signed'({2'd0, prod_r[36:8]}) - signed'({14'd0, Q16_ONE});
      denc_r <= den_r;

      zd_r     <= zc_r;
      an_r     <= num_r[30] ? 30'(-num_r) : num_r[29:0];
      ad_r     <= denc_r[25] ? 25'(-denc_r) : denc_r[24:0];
      sgn_r    <= num_r[30] ^ denc_r[25];
      denz_r   <= (denc_r == '0);
      numnz_r  <= (num_r != '0);
      numneg_r <= num_r[30];

      // A zero denominator takes the sign of the numerator; a ratio that
      // reaches one in magnitude clamps to plus or minus one.
      cdp_r.zero    <= zd_r;
      cdp_r.byp     <= denz_r || (an_r >= {5'd0, ad_r});
      cdp_r.neg_fix <= denz_r ? numneg_r : sgn_r;
      cdp_r.cfix    <= (denz_r && !numnz_r) ? 17'd0 : Q16_ONE;
      cdp_r.sgn     <= sgn_r;
      an24_r        <= an_r[23:0];
      ad24_r        <= ad_r[23:0];
    end
  end

  // Cosine magnitude |num| * 2^16 / |den|, below one here.
  cdiv_pay_t   cdp_out;
  logic        cdv_out;
  logic [15:0] cq_out;

  afib1_div #(.BW(24), .QW(16), .PW($bits(cdiv_pay_t))) u_cos_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .in_valid  (ve_r),
    .in_rem    (an24_r),
    .in_low    (16'd0),
    .in_div    (ad24_r),
    .in_pay    (cdp_r),
    .out_valid (cdv_out),
    .out_quo   (cq_out),
    .out_pay   (cdp_out)
  );

  // Stages F, G, H: cosine, its square, and 1 - c^2 in Q32.
  logic        vf_r;
  logic        vg_r;
  logic        vh_r;
  sq_pay_t     sf_r;
  sq_pay_t     sg_r;
  sq_pay_t     sh_r;
  logic [33:0] csq_r;
  logic [32:0] m_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
      vg_r <= 1'b0;
      vh_r <= 1'b0;
    end else if (ce) begin
      vf_r <= cdv_out;
      vg_r <= vf_r;
      vh_r <= vg_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      sf_r.zero <= cdp_out.zero;
      sf_r.cmag <= cdp_out.byp ? cdp_out.cfix : {1'b0, cq_out};
      // Truncation toward zero can leave a zero result, which is not negative.
      sf_r.neg  <= cdp_out.byp ? (cdp_out.neg_fix && (cdp_out.cfix != 17'd0)) :
                                 (cdp_out.sgn && (cq_out != 16'd0));

      sg_r  <= sf_r;
      csq_r <= 34'(sf_r.cmag * sf_r.cmag);

      sh_r <= sg_r;
      m_r  <= 33'(35'h1_0000_0000 - {1'b0, csq_r});
    end
  end

  // y = sqrt(2^60 - x^2) in Q30, with x = |c| << 14.
  sq_pay_t     sq_out;
  logic        sqv_out;
  logic [30:0] root_out;

  afib1_sqrt #(.K(31), .PW($bits(sq_pay_t))) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .in_valid  (vh_r),
    .in_val    ({1'b0, m_r, 28'd0}),
    .in_pay    (sh_r),
    .out_valid (sqv_out),
    .out_root  (root_out),
    .out_pay   (sq_out)
  );

  cor_pay_t           cp_in;
  cor_pay_t           cp_out;
  logic               cov_out;
  logic signed [24:0] z_out;

  assign cp_in.zero = sq_out.zero;
  assign cp_in.neg  = sq_out.neg;

  afib1_cordic #(.STEPS(ACOS_STEPS), .PW($bits(cor_pay_t))) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .in_valid  (sqv_out),
    .in_x      ({sq_out.cmag, 14'd0}),
    .in_y      (root_out),
    .in_pay    (cp_in),
    .out_valid (cov_out),
    .out_z     (z_out),
    .out_pay   (cp_out)
  );

  // Stage I: clamp the CORDIC angle to [0, 90] and mirror for negative c.
  // Stage J: rounded flip angle and the B1 saturation test.
  logic        vi_r;
  logic        zi_r;
  logic [23:0] ang_r;
  logic        vj_r;
  bdiv_pay_t   bp_r;
  logic [23:0] angj_r;
  logic [23:0] zcl;
  logic [24:0] fa_sum;

  always_comb begin
    if (z_out < 0) begin
      zcl = 24'd0;
    end else if (z_out > signed'({1'b0, DEG90_Q16})) begin
      zcl = DEG90_Q16;
    end else begin
      zcl = z_out[23:0];
    end
  end

  assign fa_sum = {1'b0, ang_r} + 25'd512;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vi_r <= 1'b0;
      vj_r <= 1'b0;
    end else if (ce) begin
      vi_r <= cov_out;
      vj_r <= vi_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      zi_r  <= cp_out.zero;
      ang_r <= cp_out.neg ? (DEG180_Q16 - zcl) : zcl;

      bp_r.zero <= zi_r;
      bp_r.fa   <= fa_sum[23:10];
      // A zero nominal flip also lands here and saturates.
      bp_r.sat  <= ({4'd0, ang_r} >= {nominal_flip_r, 16'd0});
      angj_r    <= ang_r;
    end
  end

  // B1 = angle / nominal flip; the quotient fits 16 bits unless saturated.
  bdiv_pay_t   bp_out;
  logic        bdv_out;
  logic [15:0] bq_out;

  afib1_div #(.BW(12), .QW(16), .PW($bits(bdiv_pay_t))) u_b1_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .in_valid  (vj_r),
    .in_rem    ({4'd0, angj_r[23:16]}),
    .in_low    (angj_r[15:0]),
    .in_div    (nominal_flip_r),
    .in_pay    (bp_r),
    .out_valid (bdv_out),
    .out_quo   (bq_out),
    .out_pay   (bp_out)
  );

  // Result assembly: a zero first signal forces both numbers to zero.
  logic [31:0] fin_data;
  logic [15:0] b1_val;

  assign b1_val   = bp_out.sat ? 16'hFFFF : bq_out;
  assign fin_data = bp_out.zero ? 32'd0 : {2'd0, b1_val, bp_out.fa};

  // Output register with a one-beat skid buffer behind it.
  logic        out_valid_r;
  logic [31:0] out_data_r;
  logic        out_user_r;
  logic [31:0] skid_data_r;
  logic        skid_user_r;
  logic        emerge;
  logic        out_free;

  assign emerge   = ce && bdv_out;
  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_tready) begin
        skid_valid_r <= 1'b0;
      end
    end else if (emerge) begin
      if (out_free) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_tready) begin
        out_data_r <= skid_data_r;
        out_user_r <= skid_user_r;
      end
    end else if (emerge) begin
      if (out_free) begin
        out_data_r <= fin_data;
        out_user_r <= bp_out.zero;
      end else begin
        skid_data_r <= fin_data;
        skid_user_r <= bp_out.zero;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // The skid buffer only fills when a held result is not taken.
  a_skid_fill : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && !out_tready))
    else $error("skid buffer filled while output was free");

  // A full skid buffer always sits behind a valid output.
  a_skid_behind : assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid buffer holds data with output empty");

  // A zero-signal result carries zero numbers.
  a_zero_out : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == 32'd0))
    else $error("zero-signal result with nonzero data");

  // The flip angle never exceeds 180 degrees.
  a_fa_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[13:0] <= 14'd11520))
    else $error("flip angle out of range");

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
module tb
  import afib1_pkg::*;
  ();

  // One expected result beat: angle, B1 and the zero-signal flag.
  typedef struct {
    logic [13:0] flip_angle;
    logic [15:0] b1_ratio;
    logic        zero_signal;
  } b1_result_t;

  // Keeps its own copy of the two registers, predicts the result of every
  // accepted voxel and compares the output beats in order against it.
  class b1_map_scoreboard;
    logic [12:0] rep_ratio = REP_RATIO_RST;
    logic [11:0] nominal_flip = NOMINAL_FLIP_RST;
    b1_result_t  pending_results[$];
    int          mismatches = 0;

    function void write_reg(logic [1:0] idx, logic [12:0] value);
      if (idx == CFG_IDX_REP_RATIO) rep_ratio = value;
      else if (idx == CFG_IDX_NOMINAL_FLIP) nominal_flip = value[11:0];
    endfunction

    function void note_voxel(logic [15:0] s1, logic [15:0] s2);
      b1_result_t       res;
      longint unsigned  ratio, rem, root, bitv, ang, b1;
      longint           num, den, cosv, an, ad, x, y, z, dx, dy;
      if (s1 == 0) begin
        res = '{14'd0, 16'd0, 1'b1};
        pending_results.push_back(res);
        return;
      end
      ratio = (longint'(s2) << 16) / s1;
      if (ratio > RATIO_MAX) ratio = RATIO_MAX;
      num = longint'((ratio * rep_ratio) >> 8) - 65536;
      den = longint'(longint'(rep_ratio) << 8) - longint'(ratio);
      if (den == 0) begin
        cosv = num > 0 ? 65536 : (num < 0 ? -65536 : 0);
      end else begin
        an = num < 0 ? -num : num;
        ad = den < 0 ? -den : den;
        if (an >= ad) cosv = ((num < 0) != (den < 0)) ? -65536 : 65536;
        else cosv = (num * 65536) / den;
      end
      // Arccosine: x = |c| in Q30, y = sqrt(1 - x^2), then CORDIC vectoring.
      x = (cosv < 0 ? -cosv : cosv) << 14;
      rem = (64'd1 << 60) - longint'(x * x);
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > rem) bitv >>= 2;
      while (bitv != 0) begin
        if (rem >= root + bitv) begin
          rem -= root + bitv;
          root = (root >> 1) + bitv;
        end else begin
          root >>= 1;
        end
        bitv >>= 2;
      end
      y = root;
      z = 0;
      for (int i = 0; i < 16; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y > 0) begin
          x += dx;
          y -= dy;
          z += ATAN_TAB[i];
        end else begin
          x -= dx;
          y += dy;
          z -= ATAN_TAB[i];
        end
      end
      if (z < 0) z = 0;
      if (z > DEG90_Q16) z = DEG90_Q16;
      ang = cosv < 0 ? DEG180_Q16 - z : z;
      if (nominal_flip == 0) begin
        b1 = 65535;
      end else begin
        b1 = ang / nominal_flip;
        if (b1 > 65535) b1 = 65535;
      end
      res.flip_angle = 14'((ang + 512) >> 10);
      res.b1_ratio = b1[15:0];
      res.zero_signal = 1'b0;
      pending_results.push_back(res);
    endfunction

    function void check_result(logic [31:0] data, logic user);
      b1_result_t want;
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: tdata=%h", data);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      if (data[13:0] !== want.flip_angle) begin
        $error("flip_angle: expected %0d, got %0d", want.flip_angle, data[13:0]);
        mismatches++;
      end
      if (data[29:14] !== want.b1_ratio) begin
        $error("b1_ratio: expected %0d, got %0d", want.b1_ratio, data[29:14]);
        mismatches++;
      end
      if (user !== want.zero_signal) begin
        $error("zero_signal: expected %0d, got %0d", want.zero_signal, user);
        mismatches++;
      end
    endfunction
  endclass

  localparam int PIPE_LATENCY = 99 + 16;
  localparam int CYCLE_LIMIT  = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [12:0] cfg_data = '0;

  b1_map_scoreboard sb = new();
  int voxels_accepted = 0;
  int cycle_count = 0;

  afi_flip_angle_b1_map_top dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // Mostly no gap, sometimes a few cycles, now and then a long pause.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(15, 50);
  endfunction

  // Offers one voxel and returns after the beat it was accepted on. The
  // valid line stays high straight into the next voxel when no gap is drawn.
  task automatic send_voxel(logic [15:0] s1, logic [15:0] s2);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata = {s2, s1};
    do @(posedge clk); while (!in_tready);
    sb.note_voxel(s1, s2);
    voxels_accepted++;
  endtask

  // Registers are only touched once every result is back and the pipeline
  // has had time to go fully quiet.
  task automatic write_reg(logic [1:0] idx, logic [12:0] value);
    @(negedge clk);
    in_tvalid = 1'b0;
    wait (sb.pending_results.size() == 0);
    repeat (PIPE_LATENCY + 10) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, value);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Random voxels: most have a second signal near a physically sensible
  // ratio to the first, the rest are wide open or have a zero first signal.
  task automatic send_random(int count);
    logic [15:0] s1, s2;
    int kind;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(0, 99);
      s1 = 16'($urandom);
      if (kind < 55) begin
        s2 = 16'(($urandom_range(0, 2000) * longint'(s1)) / 1000);
      end else if (kind < 90) begin
        s2 = 16'($urandom);
      end else if (kind < 95) begin
        s1 = 16'($urandom_range(0, 15));
        s2 = 16'($urandom);
      end else begin
        s1 = 16'd0;
        s2 = 16'($urandom);
      end
      send_voxel(s1, s2);
    end
  endtask

  // Output side: random back-pressure, with one long hold-off once the
  // stream is well under way so the pipeline fills and stalls its input.
  initial begin
    int stall;
    bit held_off;
    held_off = 0;
    forever begin
      @(negedge clk);
      if (!held_off && voxels_accepted >= 300) begin
        held_off = 1;
        out_tready = 1'b0;
        repeat (400) @(negedge clk);
      end
      stall = pick_gap();
      if (stall > 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
    end
  end

  // Every accepted output beat goes straight to the scoreboard.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed voxels at the reset settings (ratio 5.0, nominal 55 degrees).
    send_voxel(16'd0, 16'd0);
    send_voxel(16'd0, 16'hFFFF);
    send_voxel(16'hFFFF, 16'hFFFF);
    send_voxel(16'hFFFF, 16'd0);
    send_voxel(16'd1, 16'hFFFF);      // ratio saturates
    send_voxel(16'd1000, 16'd5000);   // denominator exactly zero
    send_voxel(16'd1000, 16'd200);    // numerator just below zero
    send_voxel(16'd1000, 16'd199);
    send_voxel(16'd1000, 16'd201);
    send_voxel(16'd1000, 16'd4999);
    send_voxel(16'd1000, 16'd5001);
    send_voxel(16'd1000, 16'd700);
    send_voxel(16'h5555, 16'hAAAA);
    send_voxel(16'hAAAA, 16'h5555);
    send_random(150);

    // Lowest legal settings; a zero-over-zero cosine needs n = 1.0.
    write_reg(CFG_IDX_REP_RATIO, 13'd257);
    write_reg(CFG_IDX_NOMINAL_FLIP, 13'd16);
    send_voxel(16'd300, 16'd300);
    send_random(150);

    write_reg(CFG_IDX_REP_RATIO, 13'd256);
    send_voxel(16'd777, 16'd777);     // both numerator and denominator zero
    send_voxel(16'd4, 16'd3);
    send_random(100);

    // Highest legal settings.
    write_reg(CFG_IDX_REP_RATIO, 13'd8191);
    write_reg(CFG_IDX_NOMINAL_FLIP, 13'd2880);
    send_voxel(16'h00FF, 16'hFFFF);
    send_random(150);

    // Out-of-range values, a zero nominal flip and unused register indexes.
    write_reg(CFG_IDX_REP_RATIO, 13'd0);
    write_reg(CFG_IDX_NOMINAL_FLIP, 13'd0);
    write_reg(2'd2, 13'h1FFF);
    write_reg(2'd3, 13'h0AAA);
    send_voxel(16'd9, 16'd4);
    send_random(100);

    write_reg(CFG_IDX_REP_RATIO, 13'h1FFF);
    write_reg(CFG_IDX_NOMINAL_FLIP, 13'h1FFF);
    send_random(100);

    write_reg(CFG_IDX_REP_RATIO, 13'($urandom_range(257, 8191)));
    write_reg(CFG_IDX_NOMINAL_FLIP, 13'($urandom_range(16, 2880)));
    send_random(180);

    @(negedge clk);
    in_tvalid = 1'b0;
    wait (sb.pending_results.size() == 0);
    repeat (PIPE_LATENCY + 10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
